// File: rtl/third_octave_band_level_meter_defines.svh
// assertion macros for the band level meter
`ifndef THIRD_OCTAVE_BAND_LEVEL_METER_DEFINES_SVH
`define THIRD_OCTAVE_BAND_LEVEL_METER_DEFINES_SVH
`ifndef SYNTH
`define TOBL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TOBL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TOBL_ASSERT_IMP(lbl, ante, cons)
`define TOBL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/tobl_pkg.sv
// shared types, constants and the log table for the band level meter
package tobl_pkg;
	localparam int BAND_COUNT = 31;
	localparam int BAND_W = 5;
	localparam int HIST_W = 32;
	localparam int COEF_W = 26;
	localparam int NCOEF = 5;
	localparam int SWORDS = 7;
	localparam int CROW_W = NCOEF * COEF_W;
	localparam int SROW_W = SWORDS * HIST_W;
	localparam int LEVEL_FLOOR_ENV = 2502;
	localparam int LOG2_CAL_Q16 = 5438;
	localparam int DB_SCALE = 6313057;
	localparam int LEVEL_MIN = -1120;
	localparam int LEVEL_MAX = 511;

	typedef enum logic [1:0] {
		OP_AUDIO  = 2'd0,
		OP_COEF   = 2'd1,
		OP_REPORT = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_GAIN   = 2'd0,
		CFG_ATTACK = 2'd1,
		CFG_DECAY  = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MIX, ST_SAT, ST_RD, ST_S1M, ST_S1A, ST_S2M, ST_S2A,
		ST_EM, ST_EW, ST_CWR, ST_LRD, ST_LLD, ST_NRM, ST_LIN, ST_LQ,
		ST_LDB, ST_LOUT
	} state_t;

	typedef logic [64:0][16:0] log_tab_t;

	// log2(1+i/64) in q.16 by repeated squaring
	function automatic log_tab_t log_tab_build();
		log_tab_t t;
		logic [63:0] x;
		logic [16:0] r;
		for (int i = 0; i <= 64; i++) begin
			x = 64'(64 + i) << 24;
			r = '0;
			if (x >= 64'h8000_0000) begin
				r = 17'd65536;
			end else begin
				for (int k = 15; k >= 0; k--) begin
					x = (x * x) >> 30;
					if (x >= 64'h8000_0000) begin
						x = x >> 1;
						r[k] = 1'b1;
					end
				end
			end
			t[i] = r;
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = log_tab_build();
endpackage

// File: rtl/tobl_ram.sv
// generic single-port-write ram with registered read
module tobl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: rtl/third_octave_band_level_meter.sv
// top level of the 31-band third-octave level meter
// usage:
// requests enter on in_valid/in_stall; op 0 is an audio sample, op 1 loads one
// biquad coefficient of one band, op 2 asks for a report of all band levels.
// in_stall is high whenever a request is in progress; the block works on one
// request at a time.
// an audio sample is mixed and saturated, then each band in turn is read, runs
// both biquad sections (multiply, then sum) and the envelope, and is written
// back (one set of five product registers serves both biquad sections, and the
// band state is read from and written back to one memory row per band).
// a coefficient write reads, merges and writes back one row of the coefficient memory.
// a report takes each band through a memory read, a five-step normalizer,
// interpolation, and two multiplies; results leave through one output
// register with out_valid/out_stall, and the report pauses while the
// receiver stalls with a result waiting.
// reset clears the band rows through per-row valid bits at once, so the block
// takes requests from the first cycle after reset; the gain, attack and decay
// registers return to 0.5, 32900 and 1098.
// config writes are taken at any cycle on cfg_write and belong between requests.
module third_octave_band_level_meter
	import tobl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [1:0]               cfg_index,
	input  logic [23:0]              cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               op,
	input  logic signed [23:0]       left_sample,
	input  logic signed [23:0]       right_sample,
	input  logic [4:0]               band_select,
	input  logic [2:0]               coef_slot,
	input  logic signed [COEF_W-1:0] coef_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [4:0]               band_index,
	output logic signed [11:0]       level_db,
	output logic                     last_band
);
	localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(BAND_COUNT - 1);

	state_t state_q, state_d;

	logic [15:0] gain_q;
	logic [23:0] attack_q, decay_q;
	logic [BAND_COUNT-1:0] cvalid_q, svalid_q;
	logic cval_rd_q, sval_rd_q;
	logic [BAND_W-1:0] band_q, cband_q;
	logic [2:0] cslot_q;
	logic signed [COEF_W-1:0] cval_q;

	logic signed [24:0] sum_q;
	logic signed [41:0] mix_q;
	logic signed [23:0] x_q;
	logic signed [57:0] p_q [NCOEF];
	logic signed [HIST_W-1:0] y0_q, y2_q;
	logic signed [57:0] eprod_q;

	logic [31:0] n_q;
	logic [4:0] e_q;
	logic floor_q;
	logic [2:0] step_q;
	logic [16:0] t0_q;
	logic [26:0] itp_q;
	logic signed [23:0] lq_q;
	logic signed [47:0] dbp_q;

	logic out_valid_q;
	logic [4:0] band_index_q;
	logic signed [11:0] level_q;
	logic last_q;

	// memory ports
	logic c_re, c_we, s_re, s_we;
	logic [BAND_W-1:0] c_raddr;
	logic [CROW_W-1:0] c_rdata, c_wdata;
	logic [SROW_W-1:0] s_rdata, s_wdata;

	tobl_ram #(.WIDTH(CROW_W), .DEPTH(BAND_COUNT)) u_coef_ram (
		.clk(clk), .we(c_we), .waddr(cband_q), .wdata(c_wdata),
		.re(c_re), .raddr(c_raddr), .rdata(c_rdata)
	);

	tobl_ram #(.WIDTH(SROW_W), .DEPTH(BAND_COUNT)) u_state_ram (
		.clk(clk), .we(s_we), .waddr(band_q), .wdata(s_wdata),
		.re(s_re), .raddr(band_q), .rdata(s_rdata)
	);

	logic acc;
	logic coef_ok;
	logic out_free;
	assign acc = in_valid && !in_stall;
	assign coef_ok = (band_select < BAND_W'(BAND_COUNT)) && (coef_slot < 3'(NCOEF));
	assign out_free = !out_valid_q || !out_stall;

	// gated views of the rows read back
	logic signed [COEF_W-1:0] cw [NCOEF];
	logic signed [HIST_W-1:0] sw [SWORDS];
	always_comb begin
		for (int k = 0; k < NCOEF; k++) begin
			cw[k] = cval_rd_q ? c_rdata[k*COEF_W +: COEF_W] : '0;
		end
		for (int j = 0; j < SWORDS; j++) begin
			sw[j] = sval_rd_q ? s_rdata[j*HIST_W +: HIST_W] : '0;
		end
	end

	// section sum, rounding and saturation
	logic signed [60:0] sec_sum;
	logic signed [36:0] sec_rnd;
	logic signed [HIST_W-1:0] sec_y;
	always_comb begin
		sec_sum = 61'(p_q[0]) + 61'(p_q[1]) + 61'(p_q[2]) - 61'(p_q[3]) - 61'(p_q[4]);
		sec_rnd = 37'((sec_sum + 61'sd8388608) >>> 24);
		if (sec_rnd > 37'sd2147483647) begin
			sec_y = 32'sh7fff_ffff;
		end else if (sec_rnd < -37'sd2147483648) begin
			sec_y = 32'sh8000_0000;
		end else begin
			sec_y = sec_rnd[HIST_W-1:0];
		end
	end

	// mixer rounding and saturation
	logic signed [28:0] mix_rnd;
	logic signed [23:0] mix_x;
	always_comb begin
		mix_rnd = 29'((mix_q + 42'sd4096) >>> 13);
		if (mix_rnd > 29'sd8388607) begin
			mix_x = 24'sh7f_ffff;
		end else if (mix_rnd < -29'sd8388608) begin
			mix_x = 24'sh80_0000;
		end else begin
			mix_x = mix_rnd[23:0];
		end
	end

	// envelope operands
	logic signed [32:0] env_v, env_mag, env_d;
	logic [23:0] rise, env_k;
	logic signed [HIST_W-1:0] env_new;
	always_comb begin
		rise = (attack_q > decay_q) ? attack_q : decay_q;
		env_mag = y2_q[HIST_W-1] ? -33'(y2_q) : 33'(y2_q);
		env_v = (env_mag > 33'sd2147483647) ? 33'sd2147483647 : env_mag;
		env_k = (env_v > 33'(sw[6])) ? rise : decay_q;
		env_d = env_v - 33'(sw[6]);
		env_new = sw[6] + HIST_W'((eprod_q + 58'sd8388608) >>> 24);
	end

	// level interpolation and output rounding
	logic [5:0] l_idx;
	logic [9:0] l_rem;
	logic [16:0] l_t0, l_t1;
	logic signed [5:0] l_ed;
	logic signed [15:0] l_db;
	logic signed [11:0] l_lvl;
	always_comb begin
		l_idx = n_q[30:25];
		l_rem = n_q[24:15];
		l_t0 = LOG_TAB[l_idx];
		l_t1 = LOG_TAB[7'(l_idx) + 7'd1];
		l_ed = $signed({1'b0, e_q}) - 6'sd23;
		l_db = 16'((dbp_q + 48'sd2147483648) >>> 32);
		if (floor_q || l_db < 16'(LEVEL_MIN)) begin
			l_lvl = 12'(LEVEL_MIN);
		end else if (l_db > 16'(LEVEL_MAX)) begin
			l_lvl = 12'(LEVEL_MAX);
		end else begin
			l_lvl = l_db[11:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (op_t'(op))
						OP_AUDIO:  state_d = ST_MIX;
						OP_COEF:   state_d = coef_ok ? ST_CWR : ST_IDLE;
						OP_REPORT: state_d = ST_LRD;
						OP_NONE:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_MIX:  state_d = ST_SAT;
			ST_SAT:  state_d = ST_RD;
			ST_RD:   state_d = ST_S1M;
			ST_S1M:  state_d = ST_S1A;
			ST_S1A:  state_d = ST_S2M;
			ST_S2M:  state_d = ST_S2A;
			ST_S2A:  state_d = ST_EM;
			ST_EM:   state_d = ST_EW;
			ST_EW:   state_d = (band_q == LAST_BAND) ? ST_IDLE : ST_RD;
			ST_CWR:  state_d = ST_IDLE;
			ST_LRD:  state_d = ST_LLD;
			ST_LLD:  state_d = ST_NRM;
			ST_NRM:  state_d = (step_q == 3'd4) ? ST_LIN : ST_NRM;
			ST_LIN:  state_d = ST_LQ;
			ST_LQ:   state_d = ST_LDB;
			ST_LDB:  state_d = ST_LOUT;
			ST_LOUT: begin
				if (out_free) begin
					state_d = (band_q == LAST_BAND) ? ST_IDLE : ST_LRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		c_re = 1'b0;
		c_we = 1'b0;
		s_re = 1'b0;
		s_we = 1'b0;
		c_raddr = band_q;
		c_wdata = cval_rd_q ? c_rdata : '0;
		c_wdata[cslot_q * COEF_W +: COEF_W] = cval_q;
		s_wdata = {env_new, sw[4], y2_q, sw[2], y0_q, sw[0], HIST_W'(x_q)};
		unique case (state_q)
			ST_IDLE: begin
				c_re = acc && (op_t'(op) == OP_COEF) && coef_ok;
				c_raddr = band_select;
			end
			ST_RD: begin
				c_re = 1'b1;
				s_re = 1'b1;
			end
			ST_EW:   s_we = 1'b1;
			ST_CWR:  c_we = 1'b1;
			ST_LRD:  s_re = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gain_q <= 16'd4096;
			attack_q <= 24'd32900;
			decay_q <= 24'd1098;
			cvalid_q <= '0;
			svalid_q <= '0;
			band_q <= '0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_GAIN:   gain_q <= cfg_data[15:0];
					CFG_ATTACK: attack_q <= cfg_data;
					CFG_DECAY:  decay_q <= cfg_data;
					CFG_NONE:   ;
				endcase
			end
			if (c_we) begin
				cvalid_q[cband_q] <= 1'b1;
			end
			if (s_we) begin
				svalid_q[band_q] <= 1'b1;
			end
			if (state_q == ST_IDLE) begin
				band_q <= '0;
			end else if ((state_q == ST_EW || (state_q == ST_LOUT && out_free))
				&& band_q != LAST_BAND) begin
				band_q <= band_q + 1'b1;
			end
			if (state_q == ST_NRM) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (state_q == ST_LOUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc) begin
			sum_q <= 25'(left_sample) + 25'(right_sample);
			cband_q <= band_select;
			cslot_q <= coef_slot;
			cval_q <= coef_value;
			if (coef_ok) begin
				cval_rd_q <= cvalid_q[band_select];
			end
		end
		if (state_q == ST_RD) begin
			cval_rd_q <= cvalid_q[band_q];
			sval_rd_q <= svalid_q[band_q];
		end
		if (state_q == ST_LRD) begin
			sval_rd_q <= svalid_q[band_q];
		end
		unique case (state_q)
			ST_MIX: mix_q <= 42'(sum_q * $signed({1'b0, gain_q}));
			ST_SAT: x_q <= mix_x;
			ST_S1M: begin
				p_q[0] <= cw[0] * HIST_W'(x_q);
				p_q[1] <= cw[1] * sw[0];
				p_q[2] <= cw[2] * sw[1];
				p_q[3] <= cw[3] * sw[2];
				p_q[4] <= cw[4] * sw[3];
			end
			ST_S1A: y0_q <= sec_y;
			ST_S2M: begin
				p_q[0] <= cw[0] * y0_q;
				p_q[1] <= cw[1] * sw[2];
				p_q[2] <= cw[2] * sw[3];
				p_q[3] <= cw[3] * sw[4];
				p_q[4] <= cw[4] * sw[5];
			end
			ST_S2A: y2_q <= sec_y;
			ST_EM:  eprod_q <= 58'($signed({1'b0, env_k}) * env_d);
			ST_LLD: begin
				n_q <= sw[6];
				e_q <= 5'd31;
				floor_q <= sw[6] <= HIST_W'(LEVEL_FLOOR_ENV);
			end
			// binary search for the leading one
			ST_NRM: begin
				unique case (step_q)
					3'd0: if (n_q[31:16] == '0) begin
						n_q <= n_q << 16;
						e_q <= e_q - 5'd16;
					end
					3'd1: if (n_q[31:24] == '0) begin
						n_q <= n_q << 8;
						e_q <= e_q - 5'd8;
					end
					3'd2: if (n_q[31:28] == '0) begin
						n_q <= n_q << 4;
						e_q <= e_q - 5'd4;
					end
					3'd3: if (n_q[31:30] == '0) begin
						n_q <= n_q << 2;
						e_q <= e_q - 5'd2;
					end
					default: if (!n_q[31]) begin
						n_q <= n_q << 1;
						e_q <= e_q - 5'd1;
					end
				endcase
			end
			ST_LIN: begin
				t0_q <= l_t0;
				itp_q <= 27'((l_t1 - l_t0) * l_rem);
			end
			ST_LQ: lq_q <= 24'($signed({l_ed, 16'b0})) + 24'($signed({1'b0, t0_q}))
				+ 24'($signed({1'b0, itp_q[26:10]})) + 24'(LOG2_CAL_Q16);
			ST_LDB: dbp_q <= 48'(lq_q * 25'sd6313057);
			ST_LOUT: if (out_free) begin
				band_index_q <= band_q;
				level_q <= l_lvl;
				last_q <= band_q == LAST_BAND;
			end
			default: ;
		endcase
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign band_index = band_index_q;
	assign level_db = level_q;
	assign last_band = last_q;

`include "third_octave_band_level_meter_defines.svh"

	`TOBL_ASSERT_NEXT(a_out_only_from_report, (state_q != ST_LOUT) && !out_valid_q, !out_valid_q)
	`TOBL_ASSERT_IMP(a_band_in_range, 1'b1, band_q <= LAST_BAND)
	`TOBL_ASSERT_NEXT(a_band_loop, (state_q == ST_EW) && (band_q != LAST_BAND), state_q == ST_RD)
endmodule
